[src/bmb_pkg.sv]
// Shared types, mode codes and sizes for the blend mode byte unit.
// Used by every module of the block but the checker; depends on nothing.
package bmb_pkg;

  localparam int unsigned DivStages = 16;  // one quotient bit per divider stage
  localparam int unsigned NumWidth  = 16;
  localparam int unsigned DenWidth  = 16;

  localparam logic [4:0] MODE_NORMAL       = 5'd0;
  localparam logic [4:0] MODE_DARKEN       = 5'd1;
  localparam logic [4:0] MODE_MULTIPLY     = 5'd2;
  localparam logic [4:0] MODE_COLOR_BURN   = 5'd3;
  localparam logic [4:0] MODE_LINEAR_BURN  = 5'd4;
  localparam logic [4:0] MODE_LIGHTEN      = 5'd5;
  localparam logic [4:0] MODE_SCREEN       = 5'd6;
  localparam logic [4:0] MODE_COLOR_DODGE  = 5'd7;
  localparam logic [4:0] MODE_LINEAR_DODGE = 5'd8;
  localparam logic [4:0] MODE_OVERLAY      = 5'd9;
  localparam logic [4:0] MODE_HARD_LIGHT   = 5'd10;
  localparam logic [4:0] MODE_SOFT_LIGHT   = 5'd11;
  localparam logic [4:0] MODE_VIVID_LIGHT  = 5'd12;
  localparam logic [4:0] MODE_LINEAR_LIGHT = 5'd13;
  localparam logic [4:0] MODE_PIN_LIGHT    = 5'd14;
  localparam logic [4:0] MODE_HARD_MIX     = 5'd15;
  localparam logic [4:0] MODE_DIFFERENCE   = 5'd16;
  localparam logic [4:0] MODE_EXCLUSION    = 5'd17;

  // Operands and products after the first register stage.
  typedef struct packed {
    logic [4:0]  mode;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [15:0] p_ab;
    logic [15:0] p_inv;
    logic [15:0] p_aa;
    logic [15:0] p_ac;
    logic [15:0] p_v;
  } stage1_t;

  // Terms that travel alongside the divider.
  typedef struct packed {
    logic [4:0]  mode;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  q_ab255;
    logic        ex_bit;
    logic [8:0]  q_ab128;
    logic [7:0]  q_inv255;
    logic [8:0]  q_inv128;
    logic [8:0]  q_ac128;
    logic [15:0] soft_hi;
    logic [15:0] soft_lo;
  } side_t;

endpackage

[src/bmb_prep.sv]
// Front stages of the blend unit: products, constant divisions and divider operands.
// Depends on bmb_pkg.
module bmb_prep (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [7:0]                    a_i,
  input  logic [7:0]                    b_i,
  input  logic [4:0]                    mode_i,
  output logic                          valid_o,
  output logic [bmb_pkg::NumWidth-1:0]  num_o,
  output logic [bmb_pkg::DenWidth-1:0]  den_o,
  output bmb_pkg::side_t                side_o
);

  bmb_pkg::stage1_t s1_d, s1_q;
  logic             v1_q, v2_q;
  logic [8:0]       b2;

  always_comb begin
    b2 = {b_i, 1'b0};
    s1_d.mode  = mode_i;
    s1_d.a     = a_i;
    s1_d.b     = b_i;
    s1_d.p_ab  = a_i * b_i;
    s1_d.p_inv = (8'd255 - a_i) * (8'd255 - b_i);
    s1_d.p_aa  = a_i * a_i;
    s1_d.p_ac  = a_i * (8'd255 - b_i);
    if (b_i <= 8'd128) begin
      s1_d.p_v = (8'd255 - a_i) * 8'(9'd255 - b2);
    end else begin
      s1_d.p_v = a_i * 8'(b2 - 9'd255);
    end
  end

  // Second stage: x/255 as (x>>8) plus one correction, x <= 65025.
  logic [8:0]  r_ab0, r_inv0, r_aa0;
  logic        ge_ab, ge_inv, ge_aa;
  logic [7:0]  r_ab;
  logic [7:0]  q_aa, r_aa, cb;
  logic [8:0]  db2;
  bmb_pkg::side_t                side_d, side_q;
  logic [bmb_pkg::NumWidth-1:0]  num_d, num_q;
  logic [bmb_pkg::DenWidth-1:0]  den_d, den_q;

  always_comb begin
    r_ab0  = {1'b0, s1_q.p_ab[7:0]} + {1'b0, s1_q.p_ab[15:8]};
    ge_ab  = r_ab0 >= 9'd255;
    r_ab   = ge_ab ? 8'(r_ab0 - 9'd255) : r_ab0[7:0];
    r_inv0 = {1'b0, s1_q.p_inv[7:0]} + {1'b0, s1_q.p_inv[15:8]};
    ge_inv = r_inv0 >= 9'd255;
    // Soft light splits a*a into a quotient and a remainder by 255 before
    // both are scaled by 255-b; the final step happens in the last stage.
    r_aa0  = {1'b0, s1_q.p_aa[7:0]} + {1'b0, s1_q.p_aa[15:8]};
    ge_aa  = r_aa0 >= 9'd255;
    q_aa   = s1_q.p_aa[15:8] + {7'd0, ge_aa};
    r_aa   = ge_aa ? 8'(r_aa0 - 9'd255) : r_aa0[7:0];
    cb     = 8'd255 - s1_q.b;
    db2    = {s1_q.b, 1'b0};

    side_d.mode     = s1_q.mode;
    side_d.a        = s1_q.a;
    side_d.b        = s1_q.b;
    side_d.q_ab255  = s1_q.p_ab[15:8] + {7'd0, ge_ab};
    side_d.ex_bit   = {r_ab, 1'b0} >= 9'd255;
    side_d.q_ab128  = s1_q.p_ab[15:7];
    side_d.q_inv255 = s1_q.p_inv[15:8] + {7'd0, ge_inv};
    side_d.q_inv128 = s1_q.p_inv[15:7];
    side_d.q_ac128  = s1_q.p_ac[15:7];
    side_d.soft_hi  = q_aa * cb;
    side_d.soft_lo  = r_aa * cb;

    num_d = '0;
    den_d = 16'd1;
    unique case (s1_q.mode)
      bmb_pkg::MODE_COLOR_BURN: begin
        num_d = s1_q.p_inv;
        den_d = {8'd0, s1_q.b};
      end
      bmb_pkg::MODE_COLOR_DODGE: begin
        num_d = s1_q.p_ab;
        den_d = {8'd0, cb};
      end
      bmb_pkg::MODE_VIVID_LIGHT: begin
        num_d = s1_q.p_v;
        if (s1_q.b <= 8'd128) begin
          den_d = {7'd0, db2};
        end else begin
          den_d = {7'd0, 9'd510 - db2};
        end
      end
      default: begin
        num_d = '0;
        den_d = 16'd1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q   <= s1_d;
      side_q <= side_d;
      num_q  <= num_d;
      den_q  <= den_d;
    end
  end

  assign valid_o = v2_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule

[src/bmb_div.sv]
// Pipelined restoring divider, one quotient bit per stage, side terms carried along.
// Depends on bmb_pkg.
module bmb_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [bmb_pkg::NumWidth-1:0]  num_i,
  input  logic [bmb_pkg::DenWidth-1:0]  den_i,
  input  bmb_pkg::side_t                side_i,
  output logic                          valid_o,
  output logic [bmb_pkg::NumWidth-1:0]  quo_o,
  output bmb_pkg::side_t                side_o
);

  localparam int unsigned N = bmb_pkg::DivStages;
  localparam int unsigned W = bmb_pkg::NumWidth;
  localparam int unsigned D = bmb_pkg::DenWidth;

  // Index 0 is the stage input; index k+1 is the register of stage k.
  logic [W-1:0]   nq_s   [N+1];
  logic [D-1:0]   rem_s  [N+1];
  logic [D-1:0]   den_s  [N+1];
  bmb_pkg::side_t side_s [N+1];
  logic           vld_s  [N+1];

  assign nq_s[0]   = num_i;
  assign rem_s[0]  = '0;
  assign den_s[0]  = den_i;
  assign side_s[0] = side_i;
  assign vld_s[0]  = valid_i;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [D:0]     trial;
    logic           ge;
    logic [W-1:0]   nq_d, nq_q;
    logic [D-1:0]   rem_d, rem_q;
    logic [D-1:0]   den_q;
    bmb_pkg::side_t side_q;
    logic           vld_q;

    // The numerator shifts out at the top while quotient bits enter at the bottom.
    always_comb begin
      trial = {rem_s[k], nq_s[k][W-1]};
      ge    = trial >= {1'b0, den_s[k]};
      rem_d = ge ? D'(trial - {1'b0, den_s[k]}) : trial[D-1:0];
      nq_d  = {nq_s[k][W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q   <= nq_d;
        rem_q  <= rem_d;
        den_q  <= den_s[k];
        side_q <= side_s[k];
      end
    end

    assign nq_s[k+1]   = nq_q;
    assign rem_s[k+1]  = rem_q;
    assign den_s[k+1]  = den_q;
    assign side_s[k+1] = side_q;
    assign vld_s[k+1]  = vld_q;
  end

  assign valid_o = vld_s[N];
  assign quo_o   = nq_s[N];
  assign side_o  = side_s[N];

endmodule

[src/bmb_mix.sv]
// Final stage: per-mode combination, clamp to 0..255 and the output register.
// Depends on bmb_pkg.
module bmb_mix (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [bmb_pkg::NumWidth-1:0]  quo_i,
  input  bmb_pkg::side_t                side_i,
  output logic                          valid_o,
  output logic [7:0]                    value_o
);

  logic signed [18:0] sa, sb, sq, res;
  logic signed [18:0] ab128, inv128, ab255, inv255, ac128;
  logic [7:0]         mn, mx, b2m;
  logic [8:0]         s_r0;
  logic               s_ge;
  logic [7:0]         s_u, s_v;
  logic [16:0]        s_acc;
  logic signed [18:0] soft_t;
  logic [7:0]         value_d, value_q;
  logic               valid_q;

  always_comb begin
    sa     = $signed({11'd0, side_i.a});
    sb     = $signed({11'd0, side_i.b});
    sq     = $signed({3'd0, quo_i});
    ab128  = $signed({10'd0, side_i.q_ab128});
    inv128 = $signed({10'd0, side_i.q_inv128});
    ab255  = $signed({11'd0, side_i.q_ab255});
    inv255 = $signed({11'd0, side_i.q_inv255});
    ac128  = $signed({10'd0, side_i.q_ac128});
    mn     = (side_i.a < side_i.b) ? side_i.a : side_i.b;
    mx     = (side_i.a > side_i.b) ? side_i.a : side_i.b;
    // Soft light's lower term a*a*(255-b)/65025: with a*a = 255*qa + ra and
    // qa*(255-b) = 255*u + v, the term is u plus one carry when
    // 255*v + ra*(255-b) reaches 65025.
    s_r0   = {1'b0, side_i.soft_hi[7:0]} + {1'b0, side_i.soft_hi[15:8]};
    s_ge   = s_r0 >= 9'd255;
    s_u    = side_i.soft_hi[15:8] + {7'd0, s_ge};
    s_v    = s_ge ? 8'(s_r0 - 9'd255) : s_r0[7:0];
    s_acc  = {1'b0, s_v, 8'd0} - {9'd0, s_v} + {1'b0, side_i.soft_lo};
    soft_t = $signed({11'd0, s_u}) + $signed({18'd0, s_acc >= 17'd65025});
    // Pin light compares a with 2b, or 2b-1 in the upper half.
    if (side_i.b <= 8'd128) begin
      b2m = ({1'b0, side_i.a} < {side_i.b, 1'b0}) ? side_i.a : 8'({side_i.b, 1'b0});
    end else begin
      b2m = ({1'b0, side_i.a} < 9'({side_i.b, 1'b0} - 9'd1)) ? side_i.a
          : 8'({side_i.b, 1'b0} - 9'd1);
    end

    unique case (side_i.mode)
      bmb_pkg::MODE_DARKEN:       res = $signed({11'd0, mn});
      bmb_pkg::MODE_MULTIPLY:     res = ab255;
      bmb_pkg::MODE_COLOR_BURN:   res = (side_i.b == 8'd0) ? 19'sd0 : sa - sq;
      bmb_pkg::MODE_LINEAR_BURN:  res = sa + sb - 19'sd255;
      bmb_pkg::MODE_LIGHTEN:      res = $signed({11'd0, mx});
      bmb_pkg::MODE_SCREEN:       res = 19'sd255 - inv255;
      bmb_pkg::MODE_COLOR_DODGE:  res = (side_i.b == 8'd255) ? 19'sd255 : sa + sq;
      bmb_pkg::MODE_LINEAR_DODGE: res = sa + sb;
      bmb_pkg::MODE_OVERLAY:      res = (side_i.a <= 8'd128) ? ab128 : 19'sd255 - inv128;
      bmb_pkg::MODE_HARD_LIGHT:   res = (side_i.b <= 8'd128) ? ab128 : 19'sd255 - inv128;
      bmb_pkg::MODE_SOFT_LIGHT: begin
        if (side_i.b <= 8'd128) begin
          res = ab128 + soft_t;
        end else begin
          res = ac128 + ((side_i.a == 8'd255) ? (sb + sb - 19'sd255) : 19'sd0);
        end
      end
      bmb_pkg::MODE_VIVID_LIGHT: begin
        // At b = 128 the result is a; the divider's quotient is not used there.
        if (side_i.b == 8'd0) begin
          res = 19'sd0;
        end else if (side_i.b < 8'd128) begin
          res = sa - sq;
        end else if (side_i.b == 8'd128) begin
          res = sa;
        end else if (side_i.b == 8'd255) begin
          res = 19'sd255;
        end else begin
          res = sa + sq;
        end
      end
      bmb_pkg::MODE_LINEAR_LIGHT: res = sa + sb + sb - 19'sd255;
      bmb_pkg::MODE_PIN_LIGHT:    res = $signed({11'd0, b2m});
      bmb_pkg::MODE_HARD_MIX:     res = (sa + sb > 19'sd255) ? 19'sd255 : 19'sd0;
      bmb_pkg::MODE_DIFFERENCE:   res = $signed({11'd0, mx - mn});
      bmb_pkg::MODE_EXCLUSION: begin
        res = sa + sb - ab255 - ab255 - $signed({18'd0, side_i.ex_bit});
      end
      default:                    res = sa;
    endcase

    if (res < 19'sd0) begin
      value_d = 8'd0;
    end else if (res > 19'sd255) begin
      value_d = 8'd255;
    end else begin
      value_d = res[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_d;
    end
  end

  assign valid_o = valid_q;
  assign value_o = value_q;

endmodule

[src/blend_mode_byte_unit.sv]
// Top level of the blend mode byte unit: config register, pipeline control, streams.
// Depends on bmb_pkg, bmb_prep, bmb_div and bmb_mix.

// The unit blends a foreground byte with a background byte under the blend mode held
// in its one configuration register, and takes one transfer per clock unless the
// output is held off. Each result passes through two stages of products and operand
// preparation, a 16-stage divider that resolves one quotient bit per stage, and the
// output register. The whole pipeline advances together; when the output is held
// off, the input stops accepting until the held result is taken.
module blend_mode_byte_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] fore_value, [15:8] back_value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // [7:0] blended_value
);

  logic [4:0]                   mode_q;
  logic                         en;
  logic                         v_prep, v_div, v_out;
  logic [bmb_pkg::NumWidth-1:0] num, quo;
  logic [bmb_pkg::DenWidth-1:0] den;
  bmb_pkg::side_t               side_prep, side_div;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= bmb_pkg::MODE_NORMAL;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  assign en              = !v_out || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = v_out;

  bmb_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .a_i     (s_axis_tdata_i[7:0]),
    .b_i     (s_axis_tdata_i[15:8]),
    .mode_i  (mode_q),
    .valid_o (v_prep),
    .num_o   (num),
    .den_o   (den),
    .side_o  (side_prep)
  );

  bmb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_prep),
    .num_i   (num),
    .den_i   (den),
    .side_i  (side_prep),
    .valid_o (v_div),
    .quo_o   (quo),
    .side_o  (side_div)
  );

  bmb_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_div),
    .quo_i   (quo),
    .side_i  (side_div),
    .valid_o (v_out),
    .value_o (m_axis_tdata_o)
  );

endmodule

[src/bmb_checker.sv]
// Port-level checker for the blend mode byte unit, with its bind statement.
// Depends only on the top level's ports.
module bmb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o
);

  logic [5:0] inflight_q;
  logic       s_xfer, m_xfer;

  assign s_xfer = s_axis_tvalid_i && s_axis_tready_o;
  assign m_xfer = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + {5'd0, s_xfer} - {5'd0, m_xfer};
    end
  end

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped during a stall");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output data changed during a stall");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> inflight_q != 6'd0)
    else $error("result offered with no transfer in flight");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 6'd19)
    else $error("more transfers in flight than pipeline stages");

endmodule

bind blend_mode_byte_unit bmb_checker u_bmb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
